[sv/pdtc_pkg.sv]
// Shared types and constants for the PD thruster position controller.
package pdtc_pkg;

  localparam int ANGLE_W  = 17;
  localparam int ERR_W    = 18;
  localparam int PREV_W   = 19;
  localparam int GAIN_W   = 20;
  localparam int PER_W    = 16;
  localparam int CFG_W    = 20;
  localparam int CH_W     = 2;
  localparam int PULSE_W  = 11;
  localparam int MUL_A_W  = 19;
  localparam int MUL_P_W  = 39;
  localparam int ACC_W    = 56;
  localparam int MAG_W    = 54;
  localparam int DIVN_W   = 27;
  localparam int DIVD_W   = 18;
  localparam int QUOT_W   = 9;
  localparam int SPLIT    = 17;

  localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [1:0] REG_DERIV_GAIN = 2'd1;
  localparam logic [1:0] REG_PERIOD_MS  = 2'd2;
  localparam logic [1:0] REG_STOP_MODE  = 2'd3;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 20'd62423;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = 20'd32060;
  localparam logic [PER_W-1:0]   PERIOD_RST     = 16'd100;
  localparam logic [GAIN_W-1:0]  DERIV_SCALE    = 20'd1000;
  localparam logic [PULSE_W-1:0] PULSE_NEUTRAL  = 11'd1500;
  localparam logic [PULSE_W-1:0] PULSE_MIN      = 11'd1000;
  localparam logic [PULSE_W-1:0] PULSE_MAX      = 11'd2000;
  localparam logic [3:0]         DIV_STEPS      = 4'd9;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_P0,
    ST_P1,
    ST_P2,
    ST_D0,
    ST_D1,
    ST_D2,
    ST_ABS,
    ST_SCALE,
    ST_SCALE2,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[sv/pdtc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module pdtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/pdtc_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module pdtc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pdtc_pkg::DIVN_W-1:0] dividend,
  input  logic [pdtc_pkg::DIVD_W-1:0] divisor,
  output logic [pdtc_pkg::QUOT_W-1:0] quotient,
  output pdtc_pkg::div_status_t       status
);

  logic [pdtc_pkg::DIVN_W-1:0] rem;
  logic [pdtc_pkg::DIVN_W-1:0] dsh;
  logic [3:0]                  cnt;
  logic                        busy;
  logic                        done;
  logic                        fits;

  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 4'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= pdtc_pkg::DIV_STEPS;
      end else if (busy) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= pdtc_pkg::DIVN_W'({divisor, 8'b0});
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quotient <= {quotient[pdtc_pkg::QUOT_W-2:0], fits};
      dsh      <= dsh >> 1;
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

[sv/pd_thruster_position_control.sv]
// Top level of the three-channel PD thruster position controller.
// A request for a controlled channel passes through the load, multiply, absolute-value,
// scale and divide states; a saturating drive value skips the divider, and stop mode or a
// channel beyond the count goes straight to the final state. One request at a time: the
// next is taken the cycle after the result enters the output register.
// Reset restores the register defaults and clears the per-channel valid bits, so every
// stored previous error reads as zero until written; there is no clearing pass.
module pd_thruster_position_control #(
  parameter int NUM_CHANNELS = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [1:0]                          cfg_index,
  input  logic [pdtc_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pdtc_pkg::CH_W-1:0]           channel,
  input  logic signed [pdtc_pkg::ANGLE_W-1:0] reference_angle,
  input  logic signed [pdtc_pkg::ANGLE_W-1:0] measured_angle,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pdtc_pkg::CH_W-1:0]           out_channel,
  output logic [pdtc_pkg::PULSE_W-1:0]        pulse_width_us,
  output logic                                saturated
);

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [pdtc_pkg::GAIN_W-1:0] prop_gain;
  logic [pdtc_pkg::GAIN_W-1:0] deriv_gain;
  logic [pdtc_pkg::PER_W-1:0]  period_ms;
  logic                        stop_mode;
  logic [pdtc_pkg::PER_W-1:0]  per_eff;

  pdtc_pkg::state_t state;
  pdtc_pkg::state_t state_next;

  logic                               in_accept;
  logic                               load_out;
  logic [pdtc_pkg::CH_W-1:0]          ch_r;
  logic [AW-1:0]                      addr;
  logic signed [pdtc_pkg::ERR_W-1:0]  e_new;
  logic signed [pdtc_pkg::ERR_W-1:0]  e_r;
  logic signed [pdtc_pkg::PREV_W-1:0] d_r;
  logic signed [pdtc_pkg::PREV_W-1:0] prev;
  logic                               skip_r;
  logic [NUM_CHANNELS-1:0]            entry_valid;

  logic                               ram_we;
  logic [pdtc_pkg::PREV_W-1:0]        ram_rdata;

  logic signed [pdtc_pkg::MUL_A_W-1:0] mul_a;
  logic [pdtc_pkg::GAIN_W-1:0]         mul_b;
  logic signed [pdtc_pkg::MUL_P_W:0]   prod_full;
  logic signed [pdtc_pkg::MUL_P_W-1:0] mul_p;

  logic signed [34:0]                 eper;
  logic signed [28:0]                 d1000;
  logic signed [pdtc_pkg::ACC_W-1:0]  acc;
  logic [pdtc_pkg::MAG_W-1:0]         mag;
  logic                               neg_r;
  logic [pdtc_pkg::ACC_W-1:0]         t3;
  logic [60:0]                        scaled;
  logic [19:0]                        thr;
  logic                               sat_now;
  logic                               sat_r;
  logic [pdtc_pkg::PULSE_W-1:0]       pulse_r;

  logic                               div_start;
  logic [pdtc_pkg::QUOT_W-1:0]        quo;
  pdtc_pkg::div_status_t              div_st;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= pdtc_pkg::PROP_GAIN_RST;
      deriv_gain <= pdtc_pkg::DERIV_GAIN_RST;
      period_ms  <= pdtc_pkg::PERIOD_RST;
      stop_mode  <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pdtc_pkg::REG_PROP_GAIN:  prop_gain  <= cfg_data;
        pdtc_pkg::REG_DERIV_GAIN: deriv_gain <= cfg_data;
        pdtc_pkg::REG_PERIOD_MS:  period_ms  <= cfg_data[pdtc_pkg::PER_W-1:0];
        pdtc_pkg::REG_STOP_MODE:  stop_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign per_eff   = (period_ms == '0) ? pdtc_pkg::PER_W'(1) : period_ms;
  assign in_stall  = (state != pdtc_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign addr      = in_accept ? AW'(channel) : AW'(ch_r);
  assign e_new     = {reference_angle[pdtc_pkg::ANGLE_W-1], reference_angle}
                   - {measured_angle[pdtc_pkg::ANGLE_W-1], measured_angle};
  assign prev      = entry_valid[AW'(ch_r)] ? ram_rdata : '0;

  pdtc_ram #(
    .WIDTH (pdtc_pkg::PREV_W),
    .DEPTH (NUM_CHANNELS)
  ) u_prev_err (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(ch_r)),
    .wdata ({e_r[pdtc_pkg::ERR_W-1], e_r}),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // Shared multiplier, registered.
  assign prod_full = mul_a * $signed({1'b0, mul_b});

  always_ff @(posedge clk) begin
    mul_p <= prod_full[pdtc_pkg::MUL_P_W-1:0];
  end

  assign thr     = (20'(per_eff) << 3) + (20'(per_eff) << 2);
  assign sat_now = (mag[53:24] > 30'(thr))
                || ((mag[53:24] == 30'(thr)) && (mag[23:0] != '0));
  assign scaled  = {mag, 7'b0} - 61'(t3);

  pdtc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (scaled[50:24]),
    .divisor  (18'(per_eff) + (18'(per_eff) << 1)),
    .quotient (quo),
    .status   (div_st)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdtc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pdtc_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (stop_mode || (32'(channel) >= NUM_CHANNELS)) begin
            state_next = pdtc_pkg::ST_FIN;
          end else begin
            state_next = pdtc_pkg::ST_LOAD;
          end
        end
      end
      pdtc_pkg::ST_LOAD:   state_next = pdtc_pkg::ST_P0;
      pdtc_pkg::ST_P0:     state_next = pdtc_pkg::ST_P1;
      pdtc_pkg::ST_P1:     state_next = pdtc_pkg::ST_P2;
      pdtc_pkg::ST_P2:     state_next = pdtc_pkg::ST_D0;
      pdtc_pkg::ST_D0:     state_next = pdtc_pkg::ST_D1;
      pdtc_pkg::ST_D1:     state_next = pdtc_pkg::ST_D2;
      pdtc_pkg::ST_D2:     state_next = pdtc_pkg::ST_ABS;
      pdtc_pkg::ST_ABS:    state_next = pdtc_pkg::ST_SCALE;
      pdtc_pkg::ST_SCALE:  state_next = sat_now ? pdtc_pkg::ST_FIN : pdtc_pkg::ST_SCALE2;
      pdtc_pkg::ST_SCALE2: state_next = pdtc_pkg::ST_DIV;
      pdtc_pkg::ST_DIV: begin
        if (div_st.done) begin
          state_next = pdtc_pkg::ST_FIN;
        end
      end
      pdtc_pkg::ST_FIN: begin
        if (load_out) begin
          state_next = pdtc_pkg::ST_IDLE;
        end
      end
      default: state_next = pdtc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      pdtc_pkg::ST_LOAD: begin
        mul_a  = {e_r[pdtc_pkg::ERR_W-1], e_r};
        mul_b  = pdtc_pkg::GAIN_W'(per_eff);
        ram_we = 1'b1;
      end
      pdtc_pkg::ST_P0: begin
        mul_a = {2'b00, mul_p[pdtc_pkg::SPLIT-1:0]};
        mul_b = prop_gain;
      end
      pdtc_pkg::ST_P1: begin
        mul_a = {eper[34], eper[34:pdtc_pkg::SPLIT]};
        mul_b = prop_gain;
      end
      pdtc_pkg::ST_P2: begin
        mul_a = d_r;
        mul_b = pdtc_pkg::DERIV_SCALE;
      end
      pdtc_pkg::ST_D0: begin
        mul_a = {2'b00, mul_p[pdtc_pkg::SPLIT-1:0]};
        mul_b = deriv_gain;
      end
      pdtc_pkg::ST_D1: begin
        mul_a = {{7{d1000[28]}}, d1000[28:pdtc_pkg::SPLIT]};
        mul_b = deriv_gain;
      end
      pdtc_pkg::ST_SCALE2: div_start = 1'b1;
      pdtc_pkg::ST_FIN:    load_out  = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ram_we) begin
      entry_valid[AW'(ch_r)] <= 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      pdtc_pkg::ST_IDLE: begin
        if (in_accept) begin
          ch_r    <= channel;
          e_r     <= e_new;
          skip_r  <= stop_mode || (32'(channel) >= NUM_CHANNELS);
          pulse_r <= pdtc_pkg::PULSE_NEUTRAL;
          sat_r   <= 1'b0;
        end
      end
      pdtc_pkg::ST_LOAD: d_r  <= {e_r[pdtc_pkg::ERR_W-1], e_r} - prev;
      pdtc_pkg::ST_P0:   eper <= mul_p[34:0];
      pdtc_pkg::ST_P1:   acc  <= {{17{mul_p[38]}}, mul_p};
      pdtc_pkg::ST_P2:   acc  <= acc + {mul_p, 17'b0};
      pdtc_pkg::ST_D0:   d1000 <= mul_p[28:0];
      pdtc_pkg::ST_D1:   acc  <= acc + {{17{mul_p[38]}}, mul_p};
      pdtc_pkg::ST_D2:   acc  <= acc + {mul_p, 17'b0};
      pdtc_pkg::ST_ABS: begin
        mag   <= acc[55] ? pdtc_pkg::MAG_W'(-acc) : acc[pdtc_pkg::MAG_W-1:0];
        neg_r <= acc[55];
      end
      pdtc_pkg::ST_SCALE: begin
        t3 <= pdtc_pkg::ACC_W'(mag) + (pdtc_pkg::ACC_W'(mag) << 1);
        if (sat_now) begin
          sat_r   <= 1'b1;
          pulse_r <= neg_r ? pdtc_pkg::PULSE_MIN : pdtc_pkg::PULSE_MAX;
        end
      end
      pdtc_pkg::ST_DIV: begin
        if (div_st.done) begin
          pulse_r <= neg_r ? pdtc_pkg::PULSE_NEUTRAL - pdtc_pkg::PULSE_W'(quo)
                           : pdtc_pkg::PULSE_NEUTRAL + pdtc_pkg::PULSE_W'(quo);
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_channel    <= ch_r;
      pulse_width_us <= pulse_r;
      saturated      <= sat_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_sat_rails: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> (pulse_width_us == pdtc_pkg::PULSE_MIN)
                            || (pulse_width_us == pdtc_pkg::PULSE_MAX))
    else $error("saturated result off the rails");

  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pulse_width_us >= pdtc_pkg::PULSE_MIN)
               && (pulse_width_us <= pdtc_pkg::PULSE_MAX))
    else $error("pulse width out of range");

  a_no_skip_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !skip_r)
    else $error("previous error written for a skipped request");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == pdtc_pkg::ST_DIV)
    else $error("divider finished outside its wait state");
`endif

endmodule

[tb/pd_thruster_position_control_test.sv]
// Self-checking testbench for the three-channel PD thruster position controller.
`timescale 1ns / 1ps

module pd_thruster_position_control_test;

  localparam int NUM_CH      = 3;
  localparam int ANGLE_LIM   = 46080;
  localparam int LONG_HOLD   = 150;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 48;
  localparam int SETTLE      = 40;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct {
    logic [pdtc_pkg::CH_W-1:0]    ch;
    logic [pdtc_pkg::PULSE_W-1:0] pulse;
    logic                         sat;
  } drive_t;

  typedef struct {
    row_kind_t                    kind;
    logic [pdtc_pkg::CH_W-1:0]    ch;
    int                           ref_a;
    int                           meas_a;
    bit                           typed;
    logic [pdtc_pkg::PULSE_W-1:0] pulse;
    logic                         sat;
    logic [1:0]                   idx;
    logic [pdtc_pkg::CFG_W-1:0]   val;
  } plan_row_t;

  logic                                clk;
  logic                                rst;
  logic                                cfg_wr_en;
  logic [1:0]                          cfg_index;
  logic [pdtc_pkg::CFG_W-1:0]          cfg_data;
  logic                                in_valid;
  logic                                in_stall;
  logic [pdtc_pkg::CH_W-1:0]           channel;
  logic signed [pdtc_pkg::ANGLE_W-1:0] reference_angle;
  logic signed [pdtc_pkg::ANGLE_W-1:0] measured_angle;
  logic                                out_valid;
  logic                                out_stall;
  logic [pdtc_pkg::CH_W-1:0]           out_channel;
  logic [pdtc_pkg::PULSE_W-1:0]        pulse_width_us;
  logic                                saturated;

  logic [pdtc_pkg::GAIN_W-1:0] prop_q;
  logic [pdtc_pkg::GAIN_W-1:0] deriv_q;
  logic [pdtc_pkg::PER_W-1:0]  period_q;
  logic                        stop_q;
  longint                      prev_err [NUM_CH];

  drive_t    expected_pulses[$];
  plan_row_t plan[$];

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  bit hold_req      = 1'b0;
  int mismatches    = 0;
  int results_seen  = 0;
  int sat_seen      = 0;
  int requests_sent = 0;
  int reg_writes    = 0;
  int idle_cycles   = 0;

  pd_thruster_position_control #(
    .NUM_CHANNELS(NUM_CH)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .channel        (channel),
    .reference_angle(reference_angle),
    .measured_angle (measured_angle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_channel    (out_channel),
    .pulse_width_us (pulse_width_us),
    .saturated      (saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic drive_t pd_drive(input logic [pdtc_pkg::CH_W-1:0] ch,
                                      input logic signed [pdtc_pkg::ANGLE_W-1:0] ref_a,
                                      input logic signed [pdtc_pkg::ANGLE_W-1:0] meas_a);
    longint err, dlt, acc, num, den, mag, quo, rem, per;
    drive_t res;
    res.ch    = ch;
    res.pulse = pdtc_pkg::PULSE_NEUTRAL;
    res.sat   = 1'b0;
    if (!stop_q && ch < NUM_CH) begin
      per = (period_q == '0) ? 64'sd1 : longint'(period_q);
      err = longint'(ref_a) - longint'(meas_a);
      dlt = err - prev_err[ch];
      acc = longint'(prop_q) * err * per + longint'(deriv_q) * 1000 * dlt;
      num = acc * 125;
      den = 3 * (64'sd1 <<< 24) * per;
      mag = (num < 0) ? -num : num;
      quo = mag / den;
      rem = mag % den;
      if (quo > 500 || (quo == 500 && rem != 0)) begin
        quo     = 500;
        res.sat = 1'b1;
      end
      res.pulse = pdtc_pkg::PULSE_W'(longint'(pdtc_pkg::PULSE_NEUTRAL)
                                     + ((num < 0) ? -quo : quo));
      prev_err[ch] = err;
    end
    return res;
  endfunction

  function automatic int rand_angle();
    if ($urandom_range(9) == 0) begin
      return ($urandom_range(1) != 0) ? ANGLE_LIM : -ANGLE_LIM;
    end
    return int'($urandom_range(2 * ANGLE_LIM)) - ANGLE_LIM;
  endfunction

  function automatic plan_row_t item_row(input logic [pdtc_pkg::CH_W-1:0] ch,
                                         input int ref_a, input int meas_a);
    plan_row_t row;
    row.kind   = ROW_ITEM;
    row.ch     = ch;
    row.ref_a  = ref_a;
    row.meas_a = meas_a;
    row.typed  = 1'b0;
    row.pulse  = pdtc_pkg::PULSE_NEUTRAL;
    row.sat    = 1'b0;
    row.idx    = pdtc_pkg::REG_PROP_GAIN;
    row.val    = '0;
    return row;
  endfunction

  function automatic plan_row_t check_row(input logic [pdtc_pkg::CH_W-1:0] ch,
                                          input int ref_a, input int meas_a,
                                          input logic [pdtc_pkg::PULSE_W-1:0] pulse,
                                          input logic sat);
    plan_row_t row;
    row       = item_row(ch, ref_a, meas_a);
    row.typed = 1'b1;
    row.pulse = pulse;
    row.sat   = sat;
    return row;
  endfunction

  function automatic plan_row_t reg_row(input logic [1:0] idx,
                                        input logic [pdtc_pkg::CFG_W-1:0] val);
    plan_row_t row;
    row      = item_row('0, 0, 0);
    row.kind = ROW_WRITE;
    row.idx  = idx;
    row.val  = val;
    return row;
  endfunction

  task automatic send(input logic [pdtc_pkg::CH_W-1:0] ch, input int ref_a,
                      input int meas_a, input bit typed,
                      input logic [pdtc_pkg::PULSE_W-1:0] t_pulse, input logic t_sat);
    drive_t want;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    channel         <= ch;
    reference_angle <= pdtc_pkg::ANGLE_W'(ref_a);
    measured_angle  <= pdtc_pkg::ANGLE_W'(meas_a);
    do @(posedge clk); while (in_stall);
    want = pd_drive(ch, pdtc_pkg::ANGLE_W'(ref_a), pdtc_pkg::ANGLE_W'(meas_a));
    if (typed) begin
      want.pulse = t_pulse;
      want.sat   = t_sat;
    end
    expected_pulses.push_back(want);
    requests_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_pulses.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [pdtc_pkg::CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      pdtc_pkg::REG_PROP_GAIN:  prop_q   = val[pdtc_pkg::GAIN_W-1:0];
      pdtc_pkg::REG_DERIV_GAIN: deriv_q  = val[pdtc_pkg::GAIN_W-1:0];
      pdtc_pkg::REG_PERIOD_MS:  period_q = val[pdtc_pkg::PER_W-1:0];
      pdtc_pkg::REG_STOP_MODE:  stop_q   = val[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic configure(input logic [pdtc_pkg::CFG_W-1:0] kp,
                           input logic [pdtc_pkg::CFG_W-1:0] kd,
                           input logic [pdtc_pkg::CFG_W-1:0] per, input logic stop);
    drain();
    write_reg(pdtc_pkg::REG_PROP_GAIN, kp);
    write_reg(pdtc_pkg::REG_DERIV_GAIN, kd);
    write_reg(pdtc_pkg::REG_PERIOD_MS, per);
    write_reg(pdtc_pkg::REG_STOP_MODE, pdtc_pkg::CFG_W'(stop));
  endtask

  initial begin : receiver
    int held;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (held = 0; held < LONG_HOLD; held++) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < snk_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    drive_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (saturated) sat_seen++;
      if (expected_pulses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with no request pending: ch %0d pulse %0d sat %0d",
                   $time, out_channel, pulse_width_us, saturated);
        end
      end else begin
        want = expected_pulses.pop_front();
        if (out_channel !== want.ch || pulse_width_us !== want.pulse ||
            saturated !== want.sat) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: expected ch %0d pulse %0d sat %0d, got ch %0d pulse %0d sat %0d",
                     $time, want.ch, want.pulse, want.sat,
                     out_channel, pulse_width_us, saturated);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int                        ref_a;
    int                        meas_a;
    logic [pdtc_pkg::CH_W-1:0] ch;
    clk             = 1'b0;
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_index       = pdtc_pkg::REG_PROP_GAIN;
    cfg_data        = '0;
    in_valid        = 1'b0;
    channel         = '0;
    reference_angle = '0;
    measured_angle  = '0;
    prop_q          = pdtc_pkg::PROP_GAIN_RST;
    deriv_q         = pdtc_pkg::DERIV_GAIN_RST;
    period_q        = pdtc_pkg::PERIOD_RST;
    stop_q          = 1'b0;
    foreach (prev_err[i]) prev_err[i] = 0;

    plan.push_back(check_row(2'd0, 0, 0, pdtc_pkg::PULSE_NEUTRAL, 1'b0));
    plan.push_back(check_row(2'd1, ANGLE_LIM, -ANGLE_LIM, pdtc_pkg::PULSE_MAX, 1'b1));
    plan.push_back(check_row(2'd2, -ANGLE_LIM, ANGLE_LIM, pdtc_pkg::PULSE_MIN, 1'b1));
    plan.push_back(check_row(2'd3, ANGLE_LIM, -ANGLE_LIM, pdtc_pkg::PULSE_NEUTRAL, 1'b0));
    plan.push_back(check_row(2'd3, -ANGLE_LIM, 0, pdtc_pkg::PULSE_NEUTRAL, 1'b0));
    plan.push_back(item_row(2'd0, 256, 0));
    plan.push_back(item_row(2'd0, 512, 256));
    plan.push_back(item_row(2'd1, 0, 0));
    plan.push_back(item_row(2'd2, -1, 0));
    plan.push_back(item_row(2'd0, 32767, 32768));
    plan.push_back(reg_row(pdtc_pkg::REG_STOP_MODE, pdtc_pkg::CFG_W'(1)));
    plan.push_back(check_row(2'd0, ANGLE_LIM, -ANGLE_LIM, pdtc_pkg::PULSE_NEUTRAL, 1'b0));
    plan.push_back(check_row(2'd1, -ANGLE_LIM, ANGLE_LIM, pdtc_pkg::PULSE_NEUTRAL, 1'b0));
    plan.push_back(reg_row(pdtc_pkg::REG_STOP_MODE, pdtc_pkg::CFG_W'(0)));
    plan.push_back(item_row(2'd0, 1000, 0));
    plan.push_back(reg_row(pdtc_pkg::REG_PERIOD_MS, pdtc_pkg::CFG_W'(0)));
    plan.push_back(item_row(2'd1, 300, 0));
    plan.push_back(item_row(2'd1, -300, 0));
    plan.push_back(reg_row(pdtc_pkg::REG_PERIOD_MS, '1));
    plan.push_back(reg_row(pdtc_pkg::REG_PROP_GAIN, '1));
    plan.push_back(reg_row(pdtc_pkg::REG_DERIV_GAIN, '0));
    plan.push_back(item_row(2'd2, 100, 0));
    plan.push_back(reg_row(pdtc_pkg::REG_PROP_GAIN, '0));
    plan.push_back(reg_row(pdtc_pkg::REG_DERIV_GAIN, '1));
    plan.push_back(item_row(2'd2, 150, 0));
    plan.push_back(item_row(2'd0, -ANGLE_LIM, -ANGLE_LIM));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send(plan[i].ch, plan[i].ref_a, plan[i].meas_a, plan[i].typed, plan[i].pulse,
             plan[i].sat);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1: configure(pdtc_pkg::CFG_W'($urandom_range(20'hFFFFF)),
                     pdtc_pkg::CFG_W'($urandom_range(100000)),
                     pdtc_pkg::CFG_W'($urandom_range(1000, 1)), 1'b0);
        2: configure('1, '1, pdtc_pkg::CFG_W'(16'hFFFF), 1'b0);
        3: configure('0, pdtc_pkg::CFG_W'($urandom_range(20'hFFFFF)),
                     pdtc_pkg::CFG_W'(1), 1'b0);
        4: configure(pdtc_pkg::CFG_W'($urandom_range(20'hFFFFF)),
                     pdtc_pkg::CFG_W'($urandom_range(20'hFFFFF)),
                     pdtc_pkg::CFG_W'($urandom_range(16'hFFFF)), 1'b1);
        5: configure(pdtc_pkg::CFG_W'($urandom_range(8191)),
                     pdtc_pkg::CFG_W'($urandom_range(8191)),
                     pdtc_pkg::CFG_W'($urandom_range(16'hFFFF, 1)), 1'b0);
        6: configure(pdtc_pkg::CFG_W'($urandom_range(20'hFFFFF)),
                     pdtc_pkg::CFG_W'($urandom_range(20'hFFFFF)),
                     pdtc_pkg::CFG_W'($urandom_range(16'hFFFF)), 1'b0);
        default: configure(pdtc_pkg::PROP_GAIN_RST, pdtc_pkg::DERIV_GAIN_RST,
                           pdtc_pkg::CFG_W'(pdtc_pkg::PERIOD_RST), 1'b0);
      endcase
      case (p % 4)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 65;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 65;
        end
        default: begin
          src_idle_pct  = 25;
          snk_stall_pct = 25;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == 8) hold_req = 1'b1;
        if (p == 4 && n == PHASE_ITEMS / 2) drain();
        ch    = ($urandom_range(11) == 0) ? 2'd3
                                          : pdtc_pkg::CH_W'($urandom_range(NUM_CH - 1));
        ref_a = rand_angle();
        case ($urandom_range(3))
          0, 1:    meas_a = ref_a + int'($urandom_range(1024)) - 512;
          2:       meas_a = ref_a + int'($urandom_range(16384)) - 8192;
          default: meas_a = rand_angle();
        endcase
        if (meas_a > ANGLE_LIM) meas_a = ANGLE_LIM;
        if (meas_a < -ANGLE_LIM) meas_a = -ANGLE_LIM;
        send(ch, ref_a, meas_a, 1'b0, pdtc_pkg::PULSE_NEUTRAL, 1'b0);
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d requests over %0d register writes: stop mode, zero and extreme periods,",
             requests_sent, reg_writes);
    $display("gain extremes, the idle channel, four idling patterns and a long output hold-off;"
             );
    $display("checked %0d results, %0d saturated, %0d mismatches.",
             results_seen, sat_seen, mismatches);
    if (mismatches == 0 && expected_pulses.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
